FILE: hdl/dft4_pkg.sv
package dft4_pkg;

    localparam int SAMPLE_BITS = 16;

    localparam int SUM_W     = SAMPLE_BITS + 2;
    localparam int DIFF_W    = SAMPLE_BITS + 1;
    localparam int ABS_W     = SAMPLE_BITS;
    localparam int SQ_W      = 2 * ABS_W;
    localparam int RAD_W     = SQ_W + 1;
    localparam int ROOT_W    = SAMPLE_BITS + 1;
    localparam int RAD_PAD_W = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 2;

    localparam int MAG0_W = 18;
    localparam int MAG1_W = 17;
    localparam int MAG2_W = 18;
    localparam int MAG3_W = 17;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_0;
        logic signed [SAMPLE_BITS-1:0] sample_1;
        logic signed [SAMPLE_BITS-1:0] sample_2;
        logic signed [SAMPLE_BITS-1:0] sample_3;
    } in_t;

    typedef struct packed {
        logic [MAG0_W-1:0] mag_0;
        logic [MAG1_W-1:0] mag_1;
        logic [MAG2_W-1:0] mag_2;
        logic [MAG3_W-1:0] mag_3;
    } out_t;

    typedef struct packed {
        logic [SUM_W-1:0] dc;
        logic [SUM_W-1:0] ny;
        logic [RAD_W-1:0] rad;
    } qe_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } qstat_t;

    typedef struct packed {
        logic [SUM_W-1:0]     dc;
        logic [SUM_W-1:0]     ny;
        logic [REM_W-1:0]     rem;
        logic [ROOT_W-1:0]    root;
        logic [RAD_PAD_W-1:0] rad;
    } bk_t;

    function automatic bk_t root_step(bk_t s);
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        bk_t r;
        r = s;
        cur = {s.rem, s.rad[RAD_PAD_W-1 -: 2]};
        trial = (REM_W + 2)'({s.root, 2'b01});
        r.rad = {s.rad[RAD_PAD_W-3:0], 2'b00};
        if (cur >= trial)
        begin
            r.rem  = REM_W'(cur - trial);
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = REM_W'(cur);
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

FILE: hdl/dft4_magnitude.sv
// Four-point DFT magnitude spectrum of a vector of four signed samples.
// Input channel: in_valid / in_stall / in_data (sample_0..sample_3); a transfer
// happens on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall / out_data (mag_0..mag_3), same rule.
// mag_0 and mag_2 are the absolute sum and alternating sum; mag_1 and mag_3
// are the floor of sqrt((s0-s2)^2 + (s1-s3)^2).
// Throughput: one item per cycle while neither channel stalls. The path from
// the input transfer to out_valid runs through two front stages
// (sums and squares), the four-entry queue, one square-root
// stage per result bit (SAMPLE_BITS + 1), and the output register.
// When the receiver stalls, the output register holds, the root pipeline
// fills, then the queue, and in_stall rises once the front stages are full.
// Reset clears all valid flags and queue pointers; the block comes out of
// reset empty and ready to take a transfer.
module dft4_magnitude (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  dft4_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output dft4_pkg::out_t out_data
);

    logic             push;
    logic             pop;
    dft4_pkg::qe_t    push_data;
    dft4_pkg::qe_t    head;
    dft4_pkg::qstat_t qstat;

    dft4_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .push      (push),
        .push_data (push_data),
        .q_full    (qstat.full)
    );

    dft4_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (qstat)
    );

    dft4_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (qstat.empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.push && qstat.full))
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.pop && qstat.empty))
        else $error("queue read while empty");

    a_side_bins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.mag_1 == out_data.mag_3))
        else $error("bin one and bin three differ");
`endif

endmodule

FILE: hdl/dft4_front.sv
module dft4_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  dft4_pkg::in_t  in_data,
    output logic           push,
    output dft4_pkg::qe_t  push_data,
    input  logic           q_full
);

    localparam int SumW  = dft4_pkg::SUM_W;
    localparam int DiffW = dft4_pkg::DIFF_W;
    localparam int AbsW  = dft4_pkg::ABS_W;
    localparam int SqW   = dft4_pkg::SQ_W;
    localparam int RadW  = dft4_pkg::RAD_W;

    logic signed [SumW-1:0]  dc_s;
    logic signed [SumW-1:0]  ny_s;
    logic signed [DiffW-1:0] re_s;
    logic signed [DiffW-1:0] im_s;

    logic            s1_valid_reg;
    logic [SumW-1:0] s1_dc_reg;
    logic [SumW-1:0] s1_ny_reg;
    logic [AbsW-1:0] s1_re_reg;
    logic [AbsW-1:0] s1_im_reg;

    logic            s2_valid_reg;
    logic [SumW-1:0] s2_dc_reg;
    logic [SumW-1:0] s2_ny_reg;
    logic [SqW-1:0]  s2_re2_reg;
    logic [SqW-1:0]  s2_im2_reg;

    logic s1_ready;
    logic s2_ready;

    always_comb
    begin
        dc_s = SumW'(in_data.sample_0) + SumW'(in_data.sample_1)
             + SumW'(in_data.sample_2) + SumW'(in_data.sample_3);
        ny_s = SumW'(in_data.sample_0) - SumW'(in_data.sample_1)
             + SumW'(in_data.sample_2) - SumW'(in_data.sample_3);
        re_s = DiffW'(in_data.sample_0) - DiffW'(in_data.sample_2);
        im_s = DiffW'(in_data.sample_1) - DiffW'(in_data.sample_3);
    end

    assign s2_ready = !s2_valid_reg || !q_full;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;
    assign push     = s2_valid_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_dc_reg <= dc_s[SumW-1] ? SumW'(-dc_s) : SumW'(dc_s);
            s1_ny_reg <= ny_s[SumW-1] ? SumW'(-ny_s) : SumW'(ny_s);
            s1_re_reg <= re_s[DiffW-1] ? AbsW'(-re_s) : AbsW'(re_s);
            s1_im_reg <= im_s[DiffW-1] ? AbsW'(-im_s) : AbsW'(im_s);
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_dc_reg  <= s1_dc_reg;
            s2_ny_reg  <= s1_ny_reg;
            s2_re2_reg <= SqW'(s1_re_reg) * SqW'(s1_re_reg);
            s2_im2_reg <= SqW'(s1_im_reg) * SqW'(s1_im_reg);
        end
    end

    always_comb
    begin
        push_data.dc  = s2_dc_reg;
        push_data.ny  = s2_ny_reg;
        push_data.rad = RadW'(s2_re2_reg) + RadW'(s2_im2_reg);
    end

endmodule

FILE: hdl/dft4_queue.sv
module dft4_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dft4_pkg::qe_t    push_data,
    input  logic             pop,
    output dft4_pkg::qe_t    head,
    output dft4_pkg::qstat_t stat
);

    localparam int Depth = dft4_pkg::Q_DEPTH;
    localparam int Aw    = dft4_pkg::Q_AW;

    dft4_pkg::qe_t entry_reg [Depth];

    logic [Aw-1:0] wr_ptr_reg;
    logic [Aw-1:0] rd_ptr_reg;
    logic [Aw:0]   count_reg;
    logic [Aw:0]   count_next;

    always_comb
    begin
        stat.push  = push;
        stat.pop   = pop;
        stat.full  = (count_reg == (Aw + 1)'(Depth));
        stat.empty = (count_reg == '0);
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign head = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/dft4_back.sv
module dft4_back (
    input  logic           clk,
    input  logic           rst_n,
    input  dft4_pkg::qe_t  head,
    input  logic           q_empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output dft4_pkg::out_t out_data
);

    localparam int RootW = dft4_pkg::ROOT_W;
    localparam int PadW  = dft4_pkg::RAD_PAD_W;
    localparam int Mag0W = dft4_pkg::MAG0_W;
    localparam int Mag1W = dft4_pkg::MAG1_W;
    localparam int Mag2W = dft4_pkg::MAG2_W;
    localparam int Mag3W = dft4_pkg::MAG3_W;

    dft4_pkg::bk_t  st_reg [RootW];
    logic [RootW-1:0] st_valid_reg;
    logic [RootW:0]   st_ready;
    dft4_pkg::bk_t  first;
    logic           out_valid_reg;
    dft4_pkg::out_t out_data_reg;

    always_comb
    begin
        first.dc   = head.dc;
        first.ny   = head.ny;
        first.rem  = '0;
        first.root = '0;
        first.rad  = PadW'(head.rad);
    end

    always_comb
    begin
        st_ready[RootW] = !out_valid_reg || !out_stall;
        for (int i = RootW - 1; i >= 0; i--)
        begin
            st_ready[i] = !st_valid_reg[i] || st_ready[i+1];
        end
    end

    assign pop = !q_empty && st_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (st_ready[0])
            begin
                st_valid_reg[0] <= !q_empty;
            end
            for (int i = 1; i < RootW; i++)
            begin
                if (st_ready[i])
                begin
                    st_valid_reg[i] <= st_valid_reg[i-1];
                end
            end
            if (st_ready[RootW])
            begin
                out_valid_reg <= st_valid_reg[RootW-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            st_reg[0] <= dft4_pkg::root_step(first);
        end
        for (int i = 1; i < RootW; i++)
        begin
            if (st_ready[i] && st_valid_reg[i-1])
            begin
                st_reg[i] <= dft4_pkg::root_step(st_reg[i-1]);
            end
        end
        if (st_ready[RootW] && st_valid_reg[RootW-1])
        begin
            out_data_reg.mag_0 <= Mag0W'(st_reg[RootW-1].dc);
            out_data_reg.mag_1 <= Mag1W'(st_reg[RootW-1].root);
            out_data_reg.mag_2 <= Mag2W'(st_reg[RootW-1].ny);
            out_data_reg.mag_3 <= Mag3W'(st_reg[RootW-1].root);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: sim/tb.sv
module tb;

    localparam int N_RANDOM       = 2000;
    localparam int CALM_ITEMS     = 300;
    localparam int DRAIN_CYCLES   = dft4_pkg::SAMPLE_BITS + 12;
    localparam int WATCHDOG_LIMIT = 1000;

    class spectrum_board;
        dft4_pkg::out_t pending_spectra[$];
        int   mismatches;
        int   spectra_checked;

        function new();
            mismatches      = 0;
            spectra_checked = 0;
        endfunction

        function dft4_pkg::out_t spectrum_of(dft4_pkg::in_t x);
            longint a, b, c, d, dc, ny, re, im;
            longint unsigned power, root, trial;
            int k;
            dft4_pkg::out_t y;
            a = $signed(x.sample_0);
            b = $signed(x.sample_1);
            c = $signed(x.sample_2);
            d = $signed(x.sample_3);
            dc = a + b + c + d;
            if (dc < 0)
                dc = -dc;
            ny = a - b + c - d;
            if (ny < 0)
                ny = -ny;
            re = a - c;
            im = b - d;
            power = longint'(re * re) + longint'(im * im);
            root = 0;
            for (k = 17; k >= 0; k--)
            begin
                trial = root | (64'd1 << k);
                if (trial * trial <= power)
                    root = trial;
            end
            y.mag_0 = dc[dft4_pkg::MAG0_W-1:0];
            y.mag_1 = root[dft4_pkg::MAG1_W-1:0];
            y.mag_2 = ny[dft4_pkg::MAG2_W-1:0];
            y.mag_3 = root[dft4_pkg::MAG3_W-1:0];
            return y;
        endfunction

        function void note_input(dft4_pkg::in_t x);
            pending_spectra.push_back(spectrum_of(x));
        endfunction

        function void compare_field(string field, longint unsigned want,
                                    longint unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(dft4_pkg::out_t y);
            dft4_pkg::out_t want;
            if (pending_spectra.size() == 0)
            begin
                $error("result transfer with nothing pending: %0d %0d %0d %0d",
                       y.mag_0, y.mag_1, y.mag_2, y.mag_3);
                mismatches++;
                return;
            end
            want = pending_spectra.pop_front();
            spectra_checked++;
            compare_field("mag_0", want.mag_0, y.mag_0);
            compare_field("mag_1", want.mag_1, y.mag_1);
            compare_field("mag_2", want.mag_2, y.mag_2);
            compare_field("mag_3", want.mag_3, y.mag_3);
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    dft4_pkg::in_t  in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    dft4_pkg::out_t out_data;

    spectrum_board board = new();

    int gap_pct      = 0;
    int stall_pct    = 0;
    bit calm         = 1'b0;
    int quiet_cycles = 0;
    int n_directed   = 0;
    int n_random     = 0;

    dft4_magnitude dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #6 clk = ~clk;

    function automatic dft4_pkg::in_t vec(int s0, int s1, int s2, int s3);
        dft4_pkg::in_t y;
        y.sample_0 = dft4_pkg::SAMPLE_BITS'(s0);
        y.sample_1 = dft4_pkg::SAMPLE_BITS'(s1);
        y.sample_2 = dft4_pkg::SAMPLE_BITS'(s2);
        y.sample_3 = dft4_pkg::SAMPLE_BITS'(s3);
        return y;
    endfunction

    function automatic int rand_sample();
        int lim;
        lim = 1 << (dft4_pkg::SAMPLE_BITS - 1);
        case ($urandom_range(5))
            0, 1: return int'($urandom_range(2 * lim - 1)) - lim;
            2:    return int'($urandom_range(128)) - 64;
            3:
            begin
                case ($urandom_range(5))
                    0: return -lim;
                    1: return -lim + 1;
                    2: return -1;
                    3: return 0;
                    4: return 1;
                    default: return lim - 1;
                endcase
            end
            4:    return $signed(dft4_pkg::SAMPLE_BITS'(
                      1 << $urandom_range(dft4_pkg::SAMPLE_BITS - 1)));
            default: return int'($urandom_range(2 * lim - 1)) - lim;
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    task automatic send_item(dft4_pkg::in_t x);
        if (!calm && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            in_data  <= dft4_pkg::in_t'({$urandom, $urandom});
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= x;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // receiver stall bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && !calm && $urandom_range(99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_input(in_data);
            if (out_valid && !out_stall)
                board.check_result(out_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("dft4_magnitude verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        dft4_pkg::in_t directed[$];
        dft4_pkg::in_t x;
        int  i;
        int  s0, s1, s2, s3;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        directed.push_back(vec(0, 0, 0, 0));
        directed.push_back(vec(32767, 32767, 32767, 32767));
        directed.push_back(vec(-32768, -32768, -32768, -32768));
        directed.push_back(vec(32767, -32768, 32767, -32768));
        directed.push_back(vec(-32768, 32767, -32768, 32767));
        directed.push_back(vec(32767, -32768, -32768, 32767));
        directed.push_back(vec(-32768, 32767, 32767, -32768));
        directed.push_back(vec(32767, 32767, -32768, -32768));
        directed.push_back(vec(-32768, -32768, 32767, 32767));
        directed.push_back(vec(1, 0, 0, 0));
        directed.push_back(vec(0, 1, 0, 0));
        directed.push_back(vec(0, 0, 1, 0));
        directed.push_back(vec(0, 0, 0, 1));
        directed.push_back(vec(-1, -1, -1, -1));
        directed.push_back(vec(1, -1, 1, -1));
        directed.push_back(vec(3, 4, 0, 0));
        directed.push_back(vec(0, 0, 3, 4));
        directed.push_back(vec(5, 12, -5, -12));
        directed.push_back(vec(2, 2, 0, 0));
        directed.push_back(vec(3, 3, 0, 0));
        directed.push_back(vec(24, 0, 0, 0));
        directed.push_back(vec(100, -7, 99, -8));

        gap_pct   = 20;
        stall_pct = 20;
        foreach (directed[j])
        begin
            send_item(directed[j]);
            n_directed++;
        end

        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i % 250 == 0)
            begin
                gap_pct   = pick_pct();
                stall_pct = pick_pct();
            end
            if (i >= N_RANDOM - CALM_ITEMS)
                calm = 1'b1;
            s0 = rand_sample();
            s1 = rand_sample();
            s2 = rand_sample();
            s3 = rand_sample();
            case ($urandom_range(9))
                0: s2 = s0;
                1: s3 = s1;
                2:
                begin
                    s2 = -s0;
                    s3 = -s1;
                end
                3:
                begin
                    s1 = s0;
                    s2 = s0;
                    s3 = s0;
                end
                default: ;
            endcase
            x = vec(s0, s1, s2, s3);
            send_item(x);
            n_random++;
        end

        in_valid <= 1'b0;
        while (board.pending_spectra.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d spectra: %0d directed vectors, %0d random vectors",
                 board.spectra_checked, n_directed, n_random);
        $display("idle and stall bursts on both channels, closing stretch at full rate");
        if (board.mismatches == 0 && board.pending_spectra.size() == 0)
            $display("dft4_magnitude verification clean");
        else
            $display("dft4_magnitude verification failed");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/dft4_pkg.sv
hdl/dft4_front.sv
hdl/dft4_queue.sv
hdl/dft4_back.sv
hdl/dft4_magnitude.sv
sim/tb.sv
